>>> design/orr_pkg.sv
// ----------------------------------------------------------------------------
// orr_pkg
// Shared types and constants of the owned-region reachability core.
// ----------------------------------------------------------------------------
package orr_pkg;
   localparam int NODE_BITS = 6;
   localparam int NODES = 64;
   localparam int SLOT_BITS = 3;
   localparam int SLOTS = 8;
   localparam int COUNT_BITS = 4;
   localparam int OWNER_BITS = 3;
   localparam int GROUP_BITS = 3;
   localparam int GROUPS = 8;

   typedef enum logic [2:0] {
      CMD_SET_SLOT = 3'd0,
      CMD_SET_COUNT = 3'd1,
      CMD_SET_OWNER = 3'd2,
      CMD_SET_GROUP = 3'd3,
      CMD_NEIGHBOR = 3'd4,
      CMD_PATH = 3'd5,
      CMD_CONTROL = 3'd6,
      CMD_NONE = 3'd7
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NQ_READ,
      ST_NQ_CHECK,
      ST_PW_START,
      ST_PW_POP,
      ST_PW_NBREAD,
      ST_PW_NBWAIT,
      ST_PW_NBCHECK,
      ST_CQ_READ,
      ST_CQ_CHECK,
      ST_DONE
   } state_type;
endpackage

>>> design/orr_ram.sv
// ----------------------------------------------------------------------------
// orr_ram
// Generic single-port-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module orr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/owned_region_reachability_core.sv
// ----------------------------------------------------------------------------
// owned_region_reachability_core
// Graph store answering neighbor, owned-path and group-control queries.
// ----------------------------------------------------------------------------
// From the request transfer to a valid response: set slot, set count and the
// unused code go straight to the response state; set owner and set group pass
// through ST_NQ_READ and ST_NQ_CHECK; neighbor query alternates those two per slot
// scanned; path query pops queued nodes and reads each neighbor; control query scans
// one node a cycle through the attribute memory read port. One item is in work at a time.
// Reset clears the count flags, present bits, register and control state at once.
module owned_region_reachability_core
   import orr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[2:0], node[8:3], slot[11:9], other_node[17:12], count[21:18],
   // holder[24:22], group[27:25], zeros[31:28]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // answer[0], held_groups[8:1], error[9], zeros[15:10]
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   state_type state_ff, state_in;
   logic [GROUPS-1:0] groups_ff;
   logic [NODES-1:0] present_ff, present_in;
   logic [NODES-1:0] cnt_valid_ff;
   logic cnt_ok_ff;
   logic [NODES-1:0] visited_ff, visited_in;

   cmd_type cmd_ff, cmd_in;
   logic [NODE_BITS-1:0] node_ff, node_in, other_ff, other_in;
   logic [OWNER_BITS-1:0] holder_ff, holder_in, owner_ff, owner_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [GROUP_BITS-1:0] grpreq_ff;
   logic [NODE_BITS:0] head_ff, head_in;
   logic [NODE_BITS-1:0] cur_ff, cur_in;
   logic [NODE_BITS:0] tail_ff, tail_in;
   logic [NODE_BITS:0] scan_ff, scan_in;
   logic [COUNT_BITS-1:0] j_ff, j_in;
   logic [NODE_BITS-1:0] nb_ff, nb_in;
   logic ans_ff, ans_in, err_ff, err_in;
   logic [GROUPS-1:0] held_ff, held_in;

   logic nt_we, at_we, q_we, ct_we;
   logic [NODE_BITS+SLOT_BITS-1:0] nt_waddr, nt_raddr;
   logic [NODE_BITS-1:0] nt_wdata, nt_rdata;
   logic [NODE_BITS-1:0] at_waddr, at_raddr;
   logic [OWNER_BITS+GROUP_BITS-1:0] at_wdata, at_rdata;
   logic [NODE_BITS-1:0] q_waddr, q_raddr;
   logic [COUNT_BITS+NODE_BITS-1:0] q_wdata, q_rdata;
   logic [NODE_BITS-1:0] ct_waddr, ct_raddr;
   logic [COUNT_BITS-1:0] ct_wdata, ct_rdata;
   logic [OWNER_BITS-1:0] own_w, own_keep;
   logic [GROUP_BITS-1:0] grp_w, grp_keep;
   logic [OWNER_BITS-1:0] rd_owner;
   logic [GROUP_BITS-1:0] rd_group;
   logic [COUNT_BITS-1:0] rd_count;
   logic [SLOT_BITS-1:0] j_idx;
   logic [NODE_BITS-1:0] cur_now;
   logic [COUNT_BITS-1:0] cnt_now;
   logic row_done;
   logic req_fire;
   logic [COUNT_BITS-1:0] sat_cnt;

   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rd_owner = at_rdata[OWNER_BITS+GROUP_BITS-1:GROUP_BITS];
   assign rd_group = at_rdata[GROUP_BITS-1:0];
   assign rd_count = cnt_ok_ff ? ct_rdata : '0;
   assign j_idx = j_ff[SLOT_BITS-1:0];
   assign cur_now = (j_ff == '0) ? q_rdata[NODE_BITS-1:0] : cur_ff;
   assign cnt_now = (j_ff == '0) ? q_rdata[COUNT_BITS+NODE_BITS-1:NODE_BITS] : cnt_ff;
   assign row_done = (j_ff >= cnt_now);

   // Owner and group share one word; a write keeps the other half as last read.
   orr_ram #(.WIDTH(NODE_BITS), .DEPTH(NODES * SLOTS)) u_nt (
      .clock(clock), .wr_en(nt_we), .wr_addr(nt_waddr), .wr_data(nt_wdata),
      .rd_addr(nt_raddr), .rd_data(nt_rdata));
   orr_ram #(.WIDTH(OWNER_BITS + GROUP_BITS), .DEPTH(NODES)) u_at (
      .clock(clock), .wr_en(at_we), .wr_addr(at_waddr), .wr_data(at_wdata),
      .rd_addr(at_raddr), .rd_data(at_rdata));
   orr_ram #(.WIDTH(COUNT_BITS + NODE_BITS), .DEPTH(NODES)) u_q (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));
   orr_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODES)) u_ct (
      .clock(clock), .wr_en(ct_we), .wr_addr(ct_waddr), .wr_data(ct_wdata),
      .rd_addr(ct_raddr), .rd_data(ct_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         groups_ff <= '0;
         present_ff <= '0;
         cnt_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         present_ff <= present_in;
         if (csr_valid) begin
            groups_ff <= csr_data[GROUPS-1:0];
         end
         if (ct_we) begin
            cnt_valid_ff[ct_waddr] <= 1'b1;
         end
      end
   end

   assign sat_cnt = (req_tdata[21:18] > 4'(SLOTS)) ? 4'(SLOTS) : req_tdata[21:18];

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      node_ff <= node_in;
      other_ff <= other_in;
      holder_ff <= holder_in;
      owner_ff <= owner_in;
      slot_ff <= slot_in;
      cnt_ff <= cnt_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      cur_ff <= cur_in;
      scan_ff <= scan_in;
      j_ff <= j_in;
      nb_ff <= nb_in;
      ans_ff <= ans_in;
      err_ff <= err_in;
      held_ff <= held_in;
      visited_ff <= visited_in;
      cnt_ok_ff <= cnt_valid_ff[ct_raddr];
      grpreq_ff <= req_tdata[27:25];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd_type'(req_tdata[2:0])) inside
                  CMD_SET_OWNER, CMD_SET_GROUP: state_in = ST_NQ_READ;
                  CMD_NEIGHBOR: state_in = ST_NQ_READ;
                  CMD_PATH: state_in = ST_PW_START;
                  CMD_CONTROL: state_in = ST_CQ_READ;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_NQ_READ: begin
            if (cmd_ff == CMD_NEIGHBOR) begin
               state_in = (!present_ff[node_ff] || j_ff >= rd_count || ans_ff)
                  ? ST_DONE : ST_NQ_CHECK;
            end else begin
               state_in = ST_NQ_CHECK;
            end
         end
         ST_NQ_CHECK: state_in = (cmd_ff == CMD_NEIGHBOR) ? ST_NQ_READ : ST_DONE;
         ST_PW_START: state_in = present_ff[node_ff] ? ST_PW_POP : ST_DONE;
         ST_PW_POP: state_in = (head_ff < tail_ff) ? ST_PW_NBREAD : ST_DONE;
         ST_PW_NBREAD: state_in = row_done ? ST_PW_POP : ST_PW_NBWAIT;
         ST_PW_NBWAIT: state_in = ST_PW_NBCHECK;
         ST_PW_NBCHECK: begin
            if (visited_ff[nb_ff]) begin
               state_in = ST_PW_NBREAD;
            end else if (!present_ff[nb_ff]) begin
               state_in = ST_DONE;
            end else if (rd_owner == owner_ff && nb_ff == other_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PW_NBREAD;
            end
         end
         ST_CQ_READ: state_in = ST_CQ_CHECK;
         ST_CQ_CHECK: state_in = scan_ff[NODE_BITS] ? ST_DONE : ST_CQ_CHECK;
         ST_DONE: state_in = rsp_tready ? ST_IDLE : ST_DONE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_DONE);
      rsp_tdata = {6'd0, err_ff, held_ff, ans_ff};
      cmd_in = cmd_ff; node_in = node_ff; other_in = other_ff;
      holder_in = holder_ff; owner_in = owner_ff; slot_in = slot_ff; cnt_in = cnt_ff;
      head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff; scan_in = scan_ff;
      j_in = j_ff; nb_in = nb_ff; ans_in = ans_ff; err_in = err_ff; held_in = held_ff;
      visited_in = visited_ff; present_in = present_ff;
      nt_we = 1'b0; nt_waddr = {node_ff, slot_ff}; nt_wdata = other_ff;
      nt_raddr = {node_ff, j_idx};
      at_we = 1'b0; at_waddr = node_ff; at_raddr = node_ff;
      own_keep = rd_owner; grp_keep = rd_group;
      own_w = own_keep; grp_w = grp_keep;
      at_wdata = {own_w, grp_w};
      q_we = 1'b0; q_waddr = tail_ff[NODE_BITS-1:0]; q_wdata = {rd_count, nb_ff};
      q_raddr = head_ff[NODE_BITS-1:0];
      ct_we = 1'b0; ct_waddr = req_tdata[8:3]; ct_wdata = sat_cnt; ct_raddr = node_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in = cmd_type'(req_tdata[2:0]);
               node_in = req_tdata[8:3];
               slot_in = req_tdata[11:9];
               other_in = req_tdata[17:12];
               holder_in = req_tdata[24:22];
               ans_in = 1'b0; err_in = 1'b0; held_in = '0; j_in = '0;
               at_raddr = req_tdata[8:3];
               ct_raddr = req_tdata[8:3];
               if (cmd_type'(req_tdata[2:0]) == CMD_SET_SLOT) begin
                  nt_we = 1'b1;
                  nt_waddr = {req_tdata[8:3], req_tdata[11:9]};
                  nt_wdata = req_tdata[17:12];
               end
               if (cmd_type'(req_tdata[2:0]) == CMD_SET_COUNT) begin
                  ct_we = 1'b1;
               end
            end
         end
         ST_NQ_READ: begin
            if (cmd_ff == CMD_SET_OWNER) begin
               at_we = 1'b1; own_w = holder_ff; at_wdata = {own_w, grp_w};
            end else if (cmd_ff == CMD_SET_GROUP) begin
               at_we = 1'b1; grp_w = grpreq_ff;
               at_wdata = {own_w, grp_w};
               present_in[node_ff] = 1'b1;
            end
         end
         ST_NQ_CHECK: begin
            if (cmd_ff == CMD_NEIGHBOR) begin
               if (nt_rdata == other_ff) ans_in = 1'b1;
               j_in = j_ff + 4'd1;
               nt_raddr = {node_ff, SLOT_BITS'(j_ff + 4'd1)};
            end
         end
         ST_PW_START: begin
            if (!present_ff[node_ff]) begin
               err_in = 1'b1;
            end else begin
               owner_in = rd_owner;
               visited_in = '0;
               visited_in[node_ff] = 1'b1;
               q_we = 1'b1; q_waddr = '0; q_wdata = {rd_count, node_ff};
               head_in = '0; tail_in = 7'd1;
            end
         end
         ST_PW_POP: begin
            j_in = '0;
         end
         ST_PW_NBREAD: begin
            if (row_done) begin
               head_in = head_ff + 7'd1;
            end
            if (j_ff == '0) begin
               cur_in = cur_now;
               cnt_in = cnt_now;
            end
            nt_raddr = {cur_now, j_idx};
         end
         ST_PW_NBWAIT: begin
            nb_in = nt_rdata;
            at_raddr = nt_rdata;
            ct_raddr = nt_rdata;
         end
         ST_PW_NBCHECK: begin
            j_in = j_ff + 4'd1;
            if (!visited_ff[nb_ff]) begin
               if (!present_ff[nb_ff]) begin
                  err_in = 1'b1;
               end else if (rd_owner == owner_ff) begin
                  if (nb_ff == other_ff) begin
                     ans_in = 1'b1;
                  end else begin
                     visited_in[nb_ff] = 1'b1;
                     if (!tail_ff[NODE_BITS]) begin
                        q_we = 1'b1;
                        tail_in = tail_ff + 7'd1;
                     end
                  end
               end
            end
         end
         ST_CQ_READ: begin
            scan_in = 7'd1;
            held_in = groups_ff;
            at_raddr = '0;
            nb_in = '0;
         end
         ST_CQ_CHECK: begin
            if (present_ff[nb_ff] && rd_owner != holder_ff) begin
               held_in[rd_group] = 1'b0;
            end
            nb_in = scan_ff[NODE_BITS-1:0];
            at_raddr = scan_ff[NODE_BITS-1:0];
            scan_in = scan_ff + 7'd1;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end
endmodule
